// ===== rtl/hppd_pkg.sv =====
// Package for the HTTP/2 padded payload deframer.
// Beat types, status codes and frame constants; no dependencies.
package hppd_pkg;

    // Width of the frame length counters
    localparam int LENGTH_BITS = 24;

    // Priority block length in octets and the exclusive flag bit
    localparam logic [2:0] PRIO_LEN = 3'd5;
    localparam logic [7:0] E_BIT    = 8'h80;

    // Frame status codes
    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_NO_PAD      = 3'd1,
        ST_SHORT_PRIO  = 3'd2,
        ST_PAD_LONG    = 3'd3,
        ST_NONZERO_PAD = 3'd4
    } status_t;

    // Input beat
    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        frame_start;
        logic [23:0] frame_length;
        logic        padded_flag;
        logic        priority_flag;
        logic        is_headers;
    } in_beat_t;

    // Result beat
    typedef struct packed {
        logic        data_valid;
        logic [7:0]  data_out;
        logic        frame_done;
        status_t     status;
        logic        priority_valid;
        logic        exclusive;
        logic [30:0] depend_stream;
        logic [7:0]  weight;
    } out_beat_t;

endpackage

// ===== rtl/hppd_core.sv =====
// Frame state registers and per-octet parse logic of the deframer.
// Depends on hppd_pkg.
module hppd_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               fire,
    input  hppd_pkg::in_beat_t beat,
    output hppd_pkg::out_beat_t result
);

    logic [hppd_pkg::LENGTH_BITS-1:0] pos_reg, pos_next;
    logic [hppd_pkg::LENGTH_BITS-1:0] len_reg, len_next;
    logic [7:0]                       pad_reg, pad_next;
    logic                             padded_reg, padded_next;
    logic                             prio_reg, prio_next;
    hppd_pkg::status_t                err_reg, err_next;
    logic                             excl_reg, excl_next;
    logic [30:0]                      dep_reg, dep_next;
    logic [7:0]                       wgt_reg, wgt_next;
    logic                             seen_reg, seen_next;

    // State update and result for one octet
    always_comb begin
        logic                             active;
        logic [2:0]                       prio_end;
        logic [2:0]                       idx;
        logic [8:0]                       pad_end;
        logic [hppd_pkg::LENGTH_BITS-1:0] data_end;

        pos_next    = pos_reg;
        len_next    = len_reg;
        pad_next    = pad_reg;
        padded_next = padded_reg;
        prio_next   = prio_reg;
        err_next    = err_reg;
        excl_next   = excl_reg;
        dep_next    = dep_reg;
        wgt_next    = wgt_reg;
        seen_next   = seen_reg;
        result      = '0;
        active      = 1'b0;

        // Frame start: latch header, clear per-frame state
        if (beat.frame_start) begin
            len_next    = beat.frame_length[hppd_pkg::LENGTH_BITS-1:0];
            padded_next = beat.padded_flag;
            prio_next   = beat.priority_flag & beat.is_headers;
            pos_next    = '0;
            pad_next    = '0;
            excl_next   = 1'b0;
            dep_next    = '0;
            wgt_next    = '0;
            seen_next   = 1'b0;
            err_next    = hppd_pkg::ST_OK;
            if (padded_next && len_next == '0) begin
                err_next = hppd_pkg::ST_NO_PAD;
            end else if (prio_next && len_next <
                         hppd_pkg::LENGTH_BITS'({1'b0, padded_next} + 2'd1)
                         + hppd_pkg::LENGTH_BITS'(3'd4)) begin
                err_next = hppd_pkg::ST_SHORT_PRIO;
            end
            if (len_next == '0) begin
                result.frame_done = 1'b1;
                result.status     = err_next;
            end else begin
                active = 1'b1;
            end
        end else if (pos_reg < len_reg) begin
            active = 1'b1;
        end

        prio_end = {2'b00, padded_next} + (prio_next ? hppd_pkg::PRIO_LEN : 3'd0);
        idx      = pos_next[2:0] - {2'b00, padded_next};
        pad_end  = {6'd0, prio_end} + {1'b0, beat.payload_byte};
        data_end = len_next - hppd_pkg::LENGTH_BITS'(pad_next);

        if (active) begin
            if (padded_next && pos_next == '0) begin
                // Pad length octet
                pad_next = beat.payload_byte;
                if (err_next == hppd_pkg::ST_OK &&
                    hppd_pkg::LENGTH_BITS'(pad_end) > len_next) begin
                    err_next = hppd_pkg::ST_PAD_LONG;
                end
            end else if (pos_next < hppd_pkg::LENGTH_BITS'(prio_end)) begin
                // Priority block, big endian dependency
                if (err_next == hppd_pkg::ST_OK || err_next == hppd_pkg::ST_PAD_LONG) begin
                    case (idx)
                        3'd0: begin
                            excl_next = |(beat.payload_byte & hppd_pkg::E_BIT);
                            dep_next  = {beat.payload_byte[6:0], 24'd0};
                        end
                        3'd1: dep_next[23:16] = beat.payload_byte;
                        3'd2: dep_next[15:8]  = beat.payload_byte;
                        3'd3: dep_next[7:0]   = beat.payload_byte;
                        default: begin
                            wgt_next  = beat.payload_byte;
                            seen_next = 1'b1;
                        end
                    endcase
                end
            end else if (err_next == hppd_pkg::ST_OK) begin
                // Data octets, then zero padding
                if (pos_next < data_end) begin
                    result.data_valid = 1'b1;
                    result.data_out   = beat.payload_byte;
                end else if (beat.payload_byte != 8'd0) begin
                    err_next = hppd_pkg::ST_NONZERO_PAD;
                end
            end
            pos_next = pos_next + 1'b1;
            if (pos_next == len_next) begin
                result.frame_done = 1'b1;
                result.status     = err_next;
            end
        end

        result.priority_valid = seen_next;
        result.exclusive      = seen_next & excl_next;
        result.depend_stream  = seen_next ? dep_next : 31'd0;
        result.weight         = seen_next ? wgt_next : 8'd0;
    end

    // Frame state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            len_reg    <= '0;
            pad_reg    <= '0;
            padded_reg <= 1'b0;
            prio_reg   <= 1'b0;
            err_reg    <= hppd_pkg::ST_OK;
            excl_reg   <= 1'b0;
            dep_reg    <= '0;
            wgt_reg    <= '0;
            seen_reg   <= 1'b0;
        end else if (fire) begin
            pos_reg    <= pos_next;
            len_reg    <= len_next;
            pad_reg    <= pad_next;
            padded_reg <= padded_next;
            prio_reg   <= prio_next;
            err_reg    <= err_next;
            excl_reg   <= excl_next;
            dep_reg    <= dep_next;
            wgt_reg    <= wgt_next;
            seen_reg   <= seen_next;
        end
    end

endmodule

// ===== rtl/http2_padded_payload_deframer.sv =====
// HTTP/2 DATA/HEADERS payload deframer: input register, parse core, result register.
// Each accepted beat waits in the input register until the result register can take its parsed result.
// Throughput: one octet per cycle while the receiver takes results; the input and result registers form a 2-deep pipe.
// Reset: synchronous active-low aresetn clears both valids and all frame state.
// Depends on hppd_pkg and hppd_core.
module http2_padded_payload_deframer (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  hppd_pkg::in_beat_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output hppd_pkg::out_beat_t m_data
);

    logic                in_valid_reg, in_valid_next;
    hppd_pkg::in_beat_t  in_data_reg;
    logic                m_valid_reg, m_valid_next;
    hppd_pkg::out_beat_t m_data_reg;
    hppd_pkg::out_beat_t result;
    logic                advance;
    logic                fire;

    // Pipe control
    assign advance       = !m_valid_reg || m_ready;
    assign fire          = in_valid_reg && advance;
    assign s_ready       = !in_valid_reg || advance;
    assign in_valid_next = (s_valid && s_ready) || (in_valid_reg && !advance);
    assign m_valid_next  = fire || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (fire) begin
            m_data_reg <= result;
        end
    end

    hppd_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .beat    (in_data_reg),
        .result  (result)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Checks
    a_data_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.data_valid && m_data.frame_done |-> m_data.status == hppd_pkg::ST_OK)
        else $error("data beat ends frame with error status");

    a_status_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.frame_done |-> m_data.status == hppd_pkg::ST_OK)
        else $error("status set outside frame end");

    a_prio_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.priority_valid |->
            !m_data.exclusive && m_data.depend_stream == 31'd0 && m_data.weight == 8'd0)
        else $error("priority fields set without priority block");

    a_prio_short: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.priority_valid && m_data.frame_done |->
            m_data.status != hppd_pkg::ST_SHORT_PRIO)
        else $error("short priority reported with priority block");

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the HTTP/2 padded payload deframer.
// Random valid/ready beats are checked against a cycle-free model of the parser.
// Depends on hppd_pkg and http2_padded_payload_deframer.
`timescale 1ns / 100ps

module testbench;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 100;
    localparam int RAND_BEATS  = 400;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    hppd_pkg::in_beat_t  s_data;
    logic                m_valid;
    logic                m_ready;
    hppd_pkg::out_beat_t m_data;

    // Stimulus and expectation stores
    hppd_pkg::in_beat_t  pending_beats[$];
    hppd_pkg::out_beat_t expected_results[$];

    int  total_beats;
    int  frame_beats;
    int  accepted_beats;
    int  results_seen;
    int  mismatches;
    int  stall_cycles;
    int  hold_left;
    int  hold_asked;
    int  hold_done;
    bit  no_idle;
    bit  in_fire;

    // Parser state mirrored from the block
    logic [23:0]       cur_pos;
    logic [23:0]       cur_len;
    logic [7:0]        cur_pad;
    logic              cur_padded;
    logic              cur_prio;
    hppd_pkg::status_t cur_err;
    logic              pr_excl;
    logic [30:0]       pr_dep;
    logic [7:0]        pr_weight;
    logic              pr_seen;

    http2_padded_payload_deframer dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Expected result of one accepted beat; updates the mirrored state
    function automatic hppd_pkg::out_beat_t deframe_step(hppd_pkg::in_beat_t b);
        hppd_pkg::out_beat_t r;
        bit                  idle_item;
        int                  prio_end;
        int                  p;
        r = '0;
        idle_item = 1'b0;
        if (b.frame_start) begin
            cur_len    = 24'(b.frame_length[hppd_pkg::LENGTH_BITS-1:0]);
            cur_padded = b.padded_flag;
            cur_prio   = b.priority_flag & b.is_headers;
            cur_pos    = '0;
            cur_pad    = '0;
            cur_err    = hppd_pkg::ST_OK;
            pr_excl    = 1'b0;
            pr_dep     = '0;
            pr_weight  = '0;
            pr_seen    = 1'b0;
            if (cur_padded && cur_len == 0)
                cur_err = hppd_pkg::ST_NO_PAD;
            else if (cur_prio &&
                     int'(cur_len) < int'(cur_padded) + int'(hppd_pkg::PRIO_LEN))
                cur_err = hppd_pkg::ST_SHORT_PRIO;
            if (cur_len == 0) begin
                r.frame_done = 1'b1;
                r.status     = cur_err;
                idle_item    = 1'b1;
            end
        end else if (cur_pos >= cur_len) begin
            idle_item = 1'b1;
        end

        if (!idle_item) begin
            prio_end = int'(cur_padded) + (cur_prio ? int'(hppd_pkg::PRIO_LEN) : 0);
            p = int'(cur_pos);
            if (cur_padded && p == 0) begin
                // pad-length octet
                cur_pad = b.payload_byte;
                if (cur_err == hppd_pkg::ST_OK && prio_end + int'(cur_pad) > int'(cur_len))
                    cur_err = hppd_pkg::ST_PAD_LONG;
            end else if (p < prio_end) begin
                // priority block: E bit, 31-bit dependency, weight
                if (cur_err == hppd_pkg::ST_OK || cur_err == hppd_pkg::ST_PAD_LONG) begin
                    case (p - int'(cur_padded))
                        0: begin
                            pr_excl = b.payload_byte[7];
                            pr_dep  = {b.payload_byte[6:0], 24'h000000};
                        end
                        1: pr_dep[23:16] = b.payload_byte;
                        2: pr_dep[15:8]  = b.payload_byte;
                        3: pr_dep[7:0]   = b.payload_byte;
                        default: begin
                            pr_weight = b.payload_byte;
                            pr_seen   = 1'b1;
                        end
                    endcase
                end
            end else if (cur_err == hppd_pkg::ST_OK) begin
                // data octets, then padding that must be zero
                if (p < int'(cur_len) - int'(cur_pad)) begin
                    r.data_valid = 1'b1;
                    r.data_out   = b.payload_byte;
                end else if (b.payload_byte != 8'h00) begin
                    cur_err = hppd_pkg::ST_NONZERO_PAD;
                end
            end
            cur_pos = cur_pos + 24'd1;
            if (cur_pos == cur_len) begin
                r.frame_done = 1'b1;
                r.status     = cur_err;
            end
        end

        if (pr_seen) begin
            r.priority_valid = 1'b1;
            r.exclusive      = pr_excl;
            r.depend_stream  = pr_dep;
            r.weight         = pr_weight;
        end
        return r;
    endfunction

    task automatic flag_mismatch(string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            flag_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                    results_seen, name, got, want));
    endtask

    function automatic logic [7:0] pick_octet(int fill);
        return (fill >= 0) ? 8'(fill) : 8'($urandom);
    endfunction

    task automatic queue_beat(hppd_pkg::in_beat_t b);
        pending_beats.push_back(b);
        total_beats++;
    endtask

    // Beats with no frame start; ignored when the block is between frames
    task automatic push_noise(int n);
        hppd_pkg::in_beat_t b;
        repeat (n) begin
            b.payload_byte  = 8'($urandom);
            b.frame_start   = 1'b0;
            b.frame_length  = 24'($urandom);
            b.padded_flag   = 1'($urandom);
            b.priority_flag = 1'($urandom);
            b.is_headers    = 1'($urandom);
            queue_beat(b);
        end
    endtask

    // One frame: pad-length octet, priority block, data, zero padding.
    // len_force overrides the declared length, emit cuts the frame short,
    // dirty puts one nonzero octet in the padding, fill fixes the random octets.
    task automatic push_frame(bit hdr, bit pad, bit prio, int data_n, int pad_n,
                              int len_force, int emit, bit dirty, int fill);
        logic [7:0]         octets[$];
        int                 decl_len;
        int                 n_beats;
        int                 dirty_at;
        int                 i;
        hppd_pkg::in_beat_t b;
        if (!pad)
            pad_n = 0;
        if (pad)
            octets.push_back(8'(pad_n));
        if (hdr && prio)
            repeat (int'(hppd_pkg::PRIO_LEN)) octets.push_back(pick_octet(fill));
        repeat (data_n) octets.push_back(pick_octet(fill));
        dirty_at = octets.size() + $urandom_range(0, (pad_n > 0) ? pad_n - 1 : 0);
        repeat (pad_n) octets.push_back(8'h00);
        if (dirty && pad_n > 0)
            octets[dirty_at] = 8'($urandom_range(1, 255));
        decl_len = (len_force >= 0) ? len_force : octets.size();
        n_beats  = (emit >= 0) ? emit : ((decl_len == 0) ? 1 : decl_len);
        for (i = 0; i < n_beats; i++) begin
            b.payload_byte = (i < octets.size()) ? octets[i] : 8'($urandom);
            if (i == 0) begin
                b.frame_start   = 1'b1;
                b.frame_length  = 24'(decl_len);
                b.padded_flag   = pad;
                b.priority_flag = prio;
                b.is_headers    = hdr;
            end else begin
                b.frame_start   = 1'b0;
                b.frame_length  = 24'($urandom);
                b.padded_flag   = 1'($urandom);
                b.priority_flag = 1'($urandom);
                b.is_headers    = 1'($urandom);
            end
            queue_beat(b);
        end
        frame_beats += n_beats;
    endtask

    // Input side: drive beats at the falling edge
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_fire) begin
            if (pending_beats.size() > 0 && (no_idle || $urandom_range(0, 99) >= 29)) begin
                s_valid <= 1'b1;
                s_data  <= pending_beats.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls plus a long hold-off on request
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_done != hold_asked) begin
            m_ready   <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= hold_done + 1;
        end else begin
            m_ready <= no_idle || ($urandom_range(0, 99) >= 29);
        end
    end

    // Accepted input beats feed the model
    always @(posedge aclk) begin
        if (!aresetn) begin
            in_fire <= 1'b0;
        end else begin
            in_fire <= s_valid && s_ready;
            if (s_valid && s_ready) begin
                expected_results.push_back(deframe_step(s_data));
                accepted_beats <= accepted_beats + 1;
            end
        end
    end

    // Result monitor
    always @(posedge aclk) begin
        hppd_pkg::out_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                flag_mismatch($sformatf("result %0d arrived with nothing expected",
                                        results_seen));
            end else begin
                want = expected_results.pop_front();
                check_field("data_valid",     m_data.data_valid,     want.data_valid);
                check_field("data_out",       m_data.data_out,       want.data_out);
                check_field("frame_done",     m_data.frame_done,     want.frame_done);
                check_field("status",         m_data.status,         want.status);
                check_field("priority_valid", m_data.priority_valid, want.priority_valid);
                check_field("exclusive",      m_data.exclusive,      want.exclusive);
                check_field("depend_stream",  m_data.depend_stream,  want.depend_stream);
                check_field("weight",         m_data.weight,         want.weight);
            end
            results_seen <= results_seen + 1;
        end
    end

    // Watchdog on cycles with no beat moving on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int  pick;
        bit  hdr;
        bit  pad;
        bit  prio;
        int  data_n;
        int  pad_n;

        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_data         = '0;
        m_ready        = 1'b0;
        total_beats    = 0;
        frame_beats    = 0;
        accepted_beats = 0;
        results_seen   = 0;
        mismatches     = 0;
        stall_cycles   = 0;
        hold_left      = 0;
        hold_asked     = 0;
        hold_done      = 0;
        no_idle        = 1'b0;
        in_fire        = 1'b0;
        cur_pos        = '0;
        cur_len        = '0;
        cur_pad        = '0;
        cur_padded     = 1'b0;
        cur_prio       = 1'b0;
        cur_err        = hppd_pkg::ST_OK;
        pr_excl        = 1'b0;
        pr_dep         = '0;
        pr_weight      = '0;
        pr_seen        = 1'b0;

        // Directed: idle beat, zero-length frames, clean frames, each error kind
        push_noise(1);
        push_frame(0, 0, 0, 0, 0, -1, -1, 0, -1);
        push_frame(0, 1, 0, 0, 0, 0, -1, 0, -1);
        push_frame(1, 0, 1, 0, 0, 0, -1, 0, -1);
        push_frame(0, 1, 0, 2, 1, -1, -1, 0, 255);
        push_frame(1, 0, 1, 1, 0, -1, -1, 0, 255);
        push_frame(1, 1, 1, 0, 0, 3, -1, 0, 0);
        push_frame(1, 1, 1, 0, 4, 6, -1, 0, -1);
        push_frame(0, 1, 0, 1, 1, -1, -1, 1, 0);

        // Random: mostly well-formed frames, some broken, cut short or oversized
        frame_beats = 0;
        while (frame_beats < RAND_BEATS) begin
            pick   = $urandom_range(0, 99);
            hdr    = 1'($urandom);
            pad    = 1'($urandom);
            prio   = 1'($urandom);
            data_n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                 : $urandom_range(0, 12);
            pad_n  = ($urandom_range(0, 49) == 0) ? $urandom_range(0, 255)
                                                  : $urandom_range(0, 6);
            if (pick < 70)
                push_frame(hdr, pad, prio, data_n, pad_n, -1, -1,
                           $urandom_range(0, 5) == 0, -1);
            else if (pick < 80)
                push_frame(hdr, pad, prio, data_n, $urandom_range(0, 255),
                           $urandom_range(0, 10), -1, 0, -1);
            else if (pick < 88)
                push_frame(hdr, pad, prio, data_n, pad_n, -1, $urandom_range(1, 4), 0, -1);
            else if (pick < 94)
                push_noise($urandom_range(1, 3));
            else
                push_frame(hdr, pad, prio, data_n, pad_n,
                           $urandom_range(0, 24'hFFFFFF), $urandom_range(1, 4), 0, -1);
        end

        // Reset is held, then released at a falling edge
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Full-rate stretch with a long receiver hold-off inside it
        while (pending_beats.size() > 300) @(posedge aclk);
        no_idle = 1'b1;
        hold_asked++;
        while (pending_beats.size() > 200) @(posedge aclk);
        no_idle = 1'b0;

        // Drain
        while (accepted_beats < total_beats) @(posedge aclk);
        while (expected_results.size() > 0) @(posedge aclk);
        repeat (4) @(posedge aclk);

        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
